[hw/rtl/cle_pkg.sv]
package cle_pkg;

  localparam int POOL_DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W       = 2;
  localparam int POS_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

[hw/rtl/cle_if.sv]
interface cle_in_if import cle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface cle_out_if import cle_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_W-1:0]     result_value;
  logic [COUNT_OUT_W-1:0] element_count;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, output result_value, output element_count, output status,
                  input ready);
  modport sink   (input valid, input result_value, input element_count, input status,
                  output ready);
endinterface

[hw/rtl/cle_ram.sv]
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/cle_mod.sv]
// restoring remainder, one dividend bit per cycle
module cle_mod import cle_pkg::*; #(
  parameter int DIV_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int STEP_W = $clog2(POS_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [POS_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem_r, dvd_r[POS_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(POS_W);
        dvd_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[POS_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_r <= diff[DIV_W-1:0];
        end else begin
          rem_r <= trial[DIV_W-1:0];
        end
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/circular_list_engine.sv]
// Circular doubly linked list of data words held in a pool of POOL_DEPTH slots. Each item is
// a command (insert, remove, read at a position, or no-op) and gives one result with the word removed
// or read, the element count afterwards and a status. Next links, prev links, data words and
// the free-slot stack each live in a one-port-read, one-port-write RAM with registered read.
// An item walks k links from the head (one link per cycle through the next-link RAM, k up to
// the count minus one); insert then does its second link write in a further state, read
// first reduces the position modulo the count in the modulo unit, and a command refused for
// an empty list or full pool goes straight to the response. The block takes a new item while
// the previous result still waits at the output. No clearing pass after reset: below a
// low-water mark the free stack is read as each slot's own index.
module circular_list_engine import cle_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_ch,
  cle_out_if.source  out_ch
);

  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_LINK,
    ST_RESP
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  logic [SLOT_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       low_r, low_nxt;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [SLOT_W-1:0]      steps_r, steps_nxt;
  logic                   head_upd_r, head_upd_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      pred_r, pred_nxt;
  logic [SLOT_W-1:0]      succ_r, succ_nxt;
  logic [VALUE_W-1:0]     res_r, res_nxt;
  status_t                stat_r, stat_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r, out_count_nxt;
  status_t                out_stat_r, out_stat_nxt;

  logic                  nxt_we, prv_we, dat_we, fre_we;
  logic [SLOT_W-1:0]     nxt_waddr, prv_waddr, dat_waddr, fre_waddr;
  logic [SLOT_W-1:0]     nxt_wdata, prv_wdata, fre_wdata;
  logic [DATA_WIDTH-1:0] dat_wdata;
  logic [SLOT_W-1:0]     nxt_rdata, prv_rdata, fre_rdata;
  logic [DATA_WIDTH-1:0] dat_rdata;
  logic [SLOT_W-1:0]     fre_raddr;

  logic                  mod_start, mod_done;
  logic [CNT_W-1:0]      mod_rem;

  logic                  in_fire;
  logic [CNT_W-1:0]      free_cnt, free_dec;
  logic [SLOT_W-1:0]     pop_slot;
  logic [POS_W-1:0]      cnt16, ins_pos;

  // free stack: entries below the low-water mark were never pushed, so are read as their own index
  assign free_cnt  = CNT_W'(POOL_DEPTH) - count_r;
  assign free_dec  = free_cnt - CNT_W'(1);
  assign fre_raddr = free_dec[SLOT_W-1:0];
  assign pop_slot  = (free_cnt == low_r) ? free_dec[SLOT_W-1:0] : fre_rdata;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cnt16       = POS_W'(count_r);
  assign ins_pos     = (in_ch.position > cnt16) ? cnt16 : in_ch.position;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    low_nxt       = low_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    head_upd_nxt  = head_upd_r;
    slot_nxt      = slot_r;
    pred_nxt      = pred_r;
    succ_nxt      = succ_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_stat_nxt  = out_stat_r;
    mod_start     = 1'b0;
    nxt_we        = 1'b0;
    nxt_waddr     = slot_r;
    nxt_wdata     = succ_r;
    prv_we        = 1'b0;
    prv_waddr     = slot_r;
    prv_wdata     = pred_r;
    dat_we        = 1'b0;
    dat_waddr     = slot_r;
    dat_wdata     = val_r;
    fre_we        = 1'b0;
    fre_waddr     = free_cnt[SLOT_W-1:0];
    fre_wdata     = cur_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = cmd_t'(in_ch.command);
          val_nxt  = DATA_WIDTH'(in_ch.value);
          cur_nxt  = head_r;
          res_nxt  = '0;
          stat_nxt = STAT_OK;
          unique case (cmd_t'(in_ch.command))
            CMD_INSERT: begin
              if (count_r == CNT_W'(POOL_DEPTH)) begin
                stat_nxt  = STAT_FULL;
                state_nxt = ST_RESP;
              end else begin
                steps_nxt    = (ins_pos == '0) ? '0 : SLOT_W'(ins_pos - POS_W'(1));
                head_upd_nxt = (ins_pos == '0);
                state_nxt    = ST_WALK;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                stat_nxt  = STAT_EMPTY;
                state_nxt = ST_RESP;
              end else begin
                steps_nxt    = (in_ch.position >= cnt16) ? SLOT_W'(count_r - CNT_W'(1))
                                                         : SLOT_W'(in_ch.position);
                head_upd_nxt = (in_ch.position == '0) || (count_r == CNT_W'(1));
                state_nxt    = ST_WALK;
              end
            end
            CMD_READ: begin
              if (count_r == '0) begin
                stat_nxt  = STAT_EMPTY;
                state_nxt = ST_RESP;
              end else begin
                mod_start = 1'b1;
                state_nxt = ST_MOD;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          steps_nxt = SLOT_W'(mod_rem);
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        // link rams hold the entries of cur_r here
        if (steps_r != '0) begin
          cur_nxt   = nxt_rdata;
          steps_nxt = steps_r - SLOT_W'(1);
        end else begin
          case (cmd_r)
            CMD_INSERT: begin
              slot_nxt = pop_slot;
              if (count_r == '0) begin
                pred_nxt = pop_slot;
                succ_nxt = pop_slot;
              end else if (head_upd_r) begin
                pred_nxt = prv_rdata;
                succ_nxt = cur_r;
              end else begin
                pred_nxt = cur_r;
                succ_nxt = nxt_rdata;
              end
              nxt_we    = 1'b1;
              nxt_waddr = slot_nxt;
              nxt_wdata = succ_nxt;
              prv_we    = 1'b1;
              prv_waddr = slot_nxt;
              prv_wdata = pred_nxt;
              dat_we    = 1'b1;
              dat_waddr = slot_nxt;
              if (free_dec < low_r) begin
                low_nxt = free_dec;
              end
              state_nxt = ST_LINK;
            end
            CMD_REMOVE: begin
              nxt_we    = 1'b1;
              nxt_waddr = prv_rdata;
              nxt_wdata = nxt_rdata;
              prv_we    = 1'b1;
              prv_waddr = nxt_rdata;
              prv_wdata = prv_rdata;
              fre_we    = 1'b1;
              if (head_upd_r) begin
                head_nxt = (count_r == CNT_W'(1)) ? '0 : nxt_rdata;
              end
              count_nxt = count_r - CNT_W'(1);
              res_nxt   = VALUE_W'(dat_rdata);
              state_nxt = ST_RESP;
            end
            default: begin
              res_nxt   = VALUE_W'(dat_rdata);
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = pred_r;
        nxt_wdata = slot_r;
        prv_we    = 1'b1;
        prv_waddr = succ_r;
        prv_wdata = slot_r;
        if (head_upd_r) begin
          head_nxt = slot_r;
        end
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_count_nxt = COUNT_OUT_W'(count_r);
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      low_r       <= CNT_W'(POOL_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    head_upd_r  <= head_upd_nxt;
    slot_r      <= slot_nxt;
    pred_r      <= pred_nxt;
    succ_r      <= succ_nxt;
    res_r       <= res_nxt;
    stat_r      <= stat_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_value  = out_value_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.status        = out_stat_r;

  cle_mod #(.DIV_W(CNT_W)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_ch.position),
    .divisor   (count_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (cur_nxt),
    .rdata (nxt_rdata)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (cur_nxt),
    .rdata (prv_rdata)
  );

  cle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (cur_nxt),
    .rdata (dat_rdata)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (fre_we),
    .waddr (fre_waddr),
    .wdata (fre_wdata),
    .raddr (fre_raddr),
    .rdata (fre_rdata)
  );

endmodule
